>>> rtl/gda_pkg.sv
// Shared constants, types and calendar tables for the Gregorian date arithmetic core.
`timescale 1ns / 1ps

package gda_pkg;

  localparam int MAX_YEAR    = 9999;
  localparam int OFFSET_BITS = 23;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DIFF_W  = 22;
  localparam int DIFF_MAX = 4194303;

  // year shifted by 400 and by the March-based month order
  localparam int YY_W  = YEAR_W + 1;
  // serial day number of any 14-bit input date
  localparam int SER_W = 23;
  localparam int S_W   = ((SER_W > OFFSET_BITS) ? SER_W : OFFSET_BITS) + 2;

  // reciprocal constants: exact over the operand ranges used here
  localparam int DIV100_M   = 5243;
  localparam int DIV100_SH  = 19;
  localparam int ERA_DAYS   = 146097;
  localparam int ERA_M_W    = 24;
  localparam longint ERA_M  = 64'd15051803;
  localparam int ERA_SH     = 41;
  localparam int CENT_DAYS  = 36524;
  localparam int DIV1460_M  = 183860;
  localparam int DIV1460_SH = 28;
  localparam int DIV365_M   = 183860;
  localparam int DIV365_SH  = 26;
  localparam int RECIP_W    = 18;

  localparam int LO_YY  = 400;
  localparam int HI_YY  = MAX_YEAR + 400;
  localparam int SER_LO = LO_YY * 365 + LO_YY / 4 - LO_YY / 100 + LO_YY / 400 + 306;
  localparam int SER_HI = HI_YY * 365 + HI_YY / 4 - HI_YY / 100 + HI_YY / 400 + 275 + 30;

  localparam int Z_W    = $clog2(SER_HI + 1);
  localparam int ERA_W  = $clog2(SER_HI / ERA_DAYS + 1) + 1;
  localparam int DOE_W  = 18;
  localparam int YOE_W  = 9;
  localparam int DOY_W  = 9;
  localparam int MP_W   = 4;
  localparam int YC_W   = $clog2(MAX_YEAR + 802) + 1;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_SUB  = 2'd1,
    MODE_DIFF = 2'd2,
    MODE_CMP  = 2'd3
  } mode_t;

  typedef struct packed {
    logic              va;
    logic              lt;
    logic              eq;
    logic              go;
    logic              rerr;
    logic [DIFF_W-1:0] diff;
  } side_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days from 1 March to the first of the month
  function automatic logic [DOY_W-1:0] month_term(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] t;
    unique case (m)
      4'd3:    t = 9'd0;
      4'd4:    t = 9'd31;
      4'd5:    t = 9'd61;
      4'd6:    t = 9'd92;
      4'd7:    t = 9'd122;
      4'd8:    t = 9'd153;
      4'd9:    t = 9'd184;
      4'd10:   t = 9'd214;
      4'd11:   t = 9'd245;
      4'd12:   t = 9'd275;
      4'd1:    t = 9'd306;
      4'd2:    t = 9'd337;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

  // same table indexed by March-based month number
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] t;
    unique case (mp)
      4'd0:    t = 9'd0;
      4'd1:    t = 9'd31;
      4'd2:    t = 9'd61;
      4'd3:    t = 9'd92;
      4'd4:    t = 9'd122;
      4'd5:    t = 9'd153;
      4'd6:    t = 9'd184;
      4'd7:    t = 9'd214;
      4'd8:    t = 9'd245;
      4'd9:    t = 9'd275;
      4'd10:   t = 9'd306;
      4'd11:   t = 9'd337;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/gregorian_date_arithmetic_core.sv
// Top level of the Gregorian date arithmetic core: thirteen-stage date pipeline.
`timescale 1ns / 1ps

// Gregorian date unit. A transfer is taken at every rising edge with start high (busy is
// tied low: the pipeline takes one transfer per clock, every clock). Its result sits on the
// result ports for one cycle with done high; the receiver cannot stall and must take it then.
// Results leave in the order the transfers arrived. Five stages turn both dates into
// serial day numbers, apply the offset and check the range, and eight stages turn the
// serial number back into a date through fixed reciprocal multipliers (era, four-year
// cycle, year of era) and compare chains (century, month). Modes: add, subtract,
// absolute difference (saturating at 4194303) and compare only. The comparison flags are
// taken on the raw fields in every mode; an illegal date A, an out-of-range result or a
// mode other than add and subtract zeroes the date fields.
module gregorian_date_arithmetic_core (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  output logic                                       busy,
  input  logic [1:0]                                 mode,
  input  logic [gda_pkg::YEAR_W-1:0]                 year_a,
  input  logic [gda_pkg::MONTH_W-1:0]                month_a,
  input  logic [gda_pkg::DAY_W-1:0]                  day_a,
  input  logic [gda_pkg::YEAR_W-1:0]                 year_b,
  input  logic [gda_pkg::MONTH_W-1:0]                month_b,
  input  logic [gda_pkg::DAY_W-1:0]                  day_b,
  input  logic signed [gda_pkg::OFFSET_BITS-1:0]     offset_days,
  output logic                                       done,
  output logic [gda_pkg::YEAR_W-1:0]                 out_year,
  output logic [gda_pkg::MONTH_W-1:0]                out_month,
  output logic [gda_pkg::DAY_W-1:0]                  out_day,
  output logic [gda_pkg::DIFF_W-1:0]                 day_difference,
  output logic                                       a_less_than_b,
  output logic                                       a_equals_b,
  output logic                                       input_valid,
  output logic                                       range_error
);

  localparam int YW   = gda_pkg::YEAR_W;
  localparam int YYW  = gda_pkg::YY_W;
  localparam int SW   = gda_pkg::SER_W;
  localparam int SSW  = gda_pkg::S_W;
  localparam int ZW   = gda_pkg::Z_W;
  localparam int EW   = gda_pkg::ERA_W;
  localparam int DEW  = gda_pkg::DOE_W;
  localparam int QP_W = YYW + 14;
  localparam int EP_W = ZW + gda_pkg::ERA_M_W;
  localparam int RP_W = DEW + gda_pkg::RECIP_W;
  localparam int D_STAGES = 8;
  localparam int LATENCY  = 13;

  // the pipeline never stalls
  assign busy = 1'b0;

  // ---------------------------------------------------------------- stage F1
  // Capture both dates, form the shifted year and start the divides by 100.
  logic [YW-1:0]                  in_y [2];
  logic [gda_pkg::MONTH_W-1:0]    in_m [2];
  logic [gda_pkg::DAY_W-1:0]      in_d [2];
  logic [YYW-1:0]                 yy_c [2];
  logic [QP_W-1:0]                pq_c [2];
  logic [QP_W-1:0]                pqq_c [2];

  logic                           f1_vld;
  logic [1:0]                     f1_mode;
  logic                           f1_lt, f1_eq;
  logic signed [SSW-1:0]          f1_off;
  logic [YW-1:0]                  f1_y [2];
  logic [YW-1:0]                  f1_q [2];
  logic [YYW-1:0]                 f1_yy [2];
  logic [YYW-1:0]                 f1_qq [2];
  logic [gda_pkg::MONTH_W-1:0]    f1_m [2];
  logic [gda_pkg::DAY_W-1:0]      f1_d [2];

  always_comb begin
    in_y[0] = year_a;  in_m[0] = month_a;  in_d[0] = day_a;
    in_y[1] = year_b;  in_m[1] = month_b;  in_d[1] = day_b;
    for (int k = 0; k < 2; k++) begin
      yy_c[k]  = YYW'(in_y[k]) + YYW'(400) - YYW'(in_m[k] <= 4'd2);
      pq_c[k]  = QP_W'(in_y[k]) * QP_W'(gda_pkg::DIV100_M);
      pqq_c[k] = QP_W'(yy_c[k]) * QP_W'(gda_pkg::DIV100_M);
    end
  end

  always_ff @(posedge clk) begin
    f1_mode <= mode;
    f1_lt   <= (year_a < year_b) || (year_a == year_b && month_a < month_b) ||
               (year_a == year_b && month_a == month_b && day_a < day_b);
    f1_eq   <= (year_a == year_b) && (month_a == month_b) && (day_a == day_b);
    f1_off  <= SSW'(offset_days);
    for (int k = 0; k < 2; k++) begin
      f1_y[k]  <= in_y[k];
      f1_q[k]  <= YW'(pq_c[k] >> gda_pkg::DIV100_SH);
      f1_yy[k] <= yy_c[k];
      f1_qq[k] <= YYW'(pqq_c[k] >> gda_pkg::DIV100_SH);
      f1_m[k]  <= in_m[k];
      f1_d[k]  <= in_d[k];
    end
  end

  // ---------------------------------------------------------------- stage F2
  // Settle the leap rule and the legality of each date; multiply out the years.
  logic                           leap_c [2];
  logic                           c100_c [2];
  logic [gda_pkg::DAY_W-1:0]      len_c [2];

  logic                           f2_vld;
  logic [1:0]                     f2_mode;
  logic                           f2_lt, f2_eq;
  logic signed [SSW-1:0]          f2_off;
  logic                           f2_ok [2];
  logic [SW-1:0]                  f2_p [2];
  logic [YYW-1:0]                 f2_yy [2];
  logic [YYW-1:0]                 f2_qq [2];
  logic [gda_pkg::DOY_W-1:0]      f2_mt [2];
  logic [gda_pkg::DAY_W-1:0]      f2_d [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      c100_c[k] = (YW'(f1_q[k] * YW'(100)) == f1_y[k]);
      leap_c[k] = ((f1_y[k][1:0] == 2'd0) && !c100_c[k]) ||
                  (c100_c[k] && (f1_q[k][1:0] == 2'd0));
      len_c[k]  = gda_pkg::month_len(f1_m[k], leap_c[k]);
    end
  end

  always_ff @(posedge clk) begin
    f2_mode <= f1_mode;
    f2_lt   <= f1_lt;
    f2_eq   <= f1_eq;
    f2_off  <= f1_off;
    for (int k = 0; k < 2; k++) begin
      f2_ok[k] <= (f1_d[k] != '0) && (f1_d[k] <= len_c[k]);
      f2_p[k]  <= SW'(f1_yy[k]) * SW'(365);
      f2_yy[k] <= f1_yy[k];
      f2_qq[k] <= f1_qq[k];
      f2_mt[k] <= gda_pkg::month_term(f1_m[k]);
      f2_d[k]  <= f1_d[k];
    end
  end

  // ---------------------------------------------------------------- stage F3
  // Sum up the serial day numbers.
  logic                           f3_vld;
  logic [1:0]                     f3_mode;
  logic                           f3_lt, f3_eq;
  logic signed [SSW-1:0]          f3_off;
  logic                           f3_ok [2];
  logic [SW-1:0]                  f3_ser [2];

  always_ff @(posedge clk) begin
    f3_mode <= f2_mode;
    f3_lt   <= f2_lt;
    f3_eq   <= f2_eq;
    f3_off  <= f2_off;
    for (int k = 0; k < 2; k++) begin
      f3_ok[k]  <= f2_ok[k];
      f3_ser[k] <= f2_p[k] + SW'(f2_yy[k] >> 2) - SW'(f2_qq[k]) + SW'(f2_qq[k] >> 2)
                   + SW'(f2_mt[k]) + SW'(f2_d[k]) - SW'(1);
    end
  end

  // ---------------------------------------------------------------- stage F4
  // Apply the offset and take the raw difference.
  logic signed [SSW-1:0]          ser_a_s, ser_b_s;

  logic                           f4_vld;
  logic [1:0]                     f4_mode;
  logic                           f4_lt, f4_eq;
  logic                           f4_ok [2];
  logic signed [SSW-1:0]          f4_s, f4_t;

  assign ser_a_s = signed'(SSW'(f3_ser[0]));
  assign ser_b_s = signed'(SSW'(f3_ser[1]));

  always_ff @(posedge clk) begin
    f4_mode <= f3_mode;
    f4_lt   <= f3_lt;
    f4_eq   <= f3_eq;
    f4_ok   <= f3_ok;
    f4_s    <= (f3_mode == gda_pkg::MODE_ADD) ? ser_a_s + f3_off : ser_a_s - f3_off;
    f4_t    <= ser_a_s - ser_b_s;
  end

  // ---------------------------------------------------------------- stage F5
  // Range check, fold and saturate the difference, gather the flags.
  logic                           arith_c, rerr_c;
  logic signed [SSW-1:0]          tabs_c;
  gda_pkg::side_t                 side_c;

  logic [D_STAGES-1:0]            dvld;
  gda_pkg::side_t                 side_q [D_STAGES];
  logic [ZW-1:0]                  f5_z;

  always_comb begin
    arith_c = f4_ok[0] && ((f4_mode == gda_pkg::MODE_ADD) || (f4_mode == gda_pkg::MODE_SUB));
    rerr_c  = arith_c && ((f4_s < SSW'(gda_pkg::SER_LO)) || (f4_s > SSW'(gda_pkg::SER_HI)));
    tabs_c  = (f4_t < 0) ? -f4_t : f4_t;
    side_c.va   = f4_ok[0];
    side_c.lt   = f4_lt;
    side_c.eq   = f4_eq;
    side_c.go   = arith_c && !rerr_c;
    side_c.rerr = rerr_c;
    side_c.diff = '0;
    if (f4_ok[0] && f4_ok[1] && (f4_mode == gda_pkg::MODE_DIFF)) begin
      side_c.diff = (tabs_c > SSW'(gda_pkg::DIFF_MAX)) ? gda_pkg::DIFF_W'(gda_pkg::DIFF_MAX)
                                                       : gda_pkg::DIFF_W'(tabs_c);
    end
  end

  always_ff @(posedge clk) begin
    side_q[0] <= side_c;
    f5_z      <= ZW'(f4_s);
    for (int i = 1; i < D_STAGES; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // ---------------------------------------------------------------- stages D1..D7
  // Serial number back to a date: era, day of era, year of era, day of year, month.
  logic [EP_W-1:0]                era_p;
  logic [RP_W-1:0]                c1460_p, y365_p;
  logic [2:0]                     cent_c;
  logic [gda_pkg::MP_W-1:0]       mp_c;

  logic [ZW-1:0]                  d1_z;
  logic [EW-1:0]                  d1_era, d2_era, d3_era, d4_era, d5_era, d6_era, d7_era;
  logic [DEW-1:0]                 d2_doe, d3_doe, d4_num, d4_doe, d5_doe;
  logic [6:0]                     d3_c1460;
  logic [2:0]                     d3_cent;
  logic                           d3_last;
  logic [gda_pkg::YOE_W-1:0]      d5_yoe, d6_yoe, d7_yoe;
  logic [gda_pkg::DOY_W-1:0]      d6_doy, d7_doy;
  logic [gda_pkg::MP_W-1:0]       d7_mp;

  assign era_p   = EP_W'(f5_z) * EP_W'(gda_pkg::ERA_M);
  assign c1460_p = RP_W'(d2_doe) * RP_W'(gda_pkg::DIV1460_M);
  assign y365_p  = RP_W'(d4_num) * RP_W'(gda_pkg::DIV365_M);

  always_comb begin
    cent_c = '0;
    for (int k = 1; k <= 4; k++) begin
      cent_c = cent_c + 3'(d2_doe >= DEW'(gda_pkg::CENT_DAYS * k));
    end
    mp_c = '0;
    for (int k = 1; k < 12; k++) begin
      mp_c = mp_c + gda_pkg::MP_W'(d6_doy >= gda_pkg::month_start(gda_pkg::MP_W'(k)));
    end
  end

  always_ff @(posedge clk) begin
    // D1: era by reciprocal
    d1_z     <= f5_z;
    d1_era   <= EW'(era_p >> gda_pkg::ERA_SH);
    // D2: day of era
    d2_era   <= d1_era;
    d2_doe   <= DEW'(d1_z - ZW'(d1_era) * ZW'(gda_pkg::ERA_DAYS));
    // D3: leap-day corrections
    d3_era   <= d2_era;
    d3_doe   <= d2_doe;
    d3_c1460 <= 7'(c1460_p >> gda_pkg::DIV1460_SH);
    d3_cent  <= cent_c;
    d3_last  <= (d2_doe == DEW'(gda_pkg::ERA_DAYS - 1));
    // D4: corrected day count
    d4_era   <= d3_era;
    d4_doe   <= d3_doe;
    d4_num   <= d3_doe - DEW'(d3_c1460) + DEW'(d3_cent) - DEW'(d3_last);
    // D5: year of era
    d5_era   <= d4_era;
    d5_doe   <= d4_doe;
    d5_yoe   <= gda_pkg::YOE_W'(y365_p >> gda_pkg::DIV365_SH);
    // D6: day of the March-based year
    d6_era   <= d5_era;
    d6_yoe   <= d5_yoe;
    d6_doy   <= gda_pkg::DOY_W'(d5_doe - (DEW'(d5_yoe) * DEW'(365) + DEW'(d5_yoe >> 2)
                - DEW'(d5_yoe >= 9'd100) - DEW'(d5_yoe >= 9'd200) - DEW'(d5_yoe >= 9'd300)));
    // D7: March-based month
    d7_era   <= d6_era;
    d7_yoe   <= d6_yoe;
    d7_doy   <= d6_doy;
    d7_mp    <= mp_c;
  end

  // ---------------------------------------------------------------- output stage
  // Finish day, month and year; zero the date on error or outside the add modes.
  localparam int YC_W_L = gda_pkg::YC_W;
  logic [gda_pkg::MONTH_W-1:0]    mo_c;
  logic [YC_W_L-1:0]              yr_c;

  assign mo_c = (d7_mp < 4'd10) ? d7_mp + 4'd3 : d7_mp - 4'd9;
  assign yr_c = YC_W_L'(d7_yoe) + YC_W_L'(d7_era) * YC_W_L'(400) + YC_W_L'(mo_c <= 4'd2)
                - YC_W_L'(400);

  always_ff @(posedge clk) begin
    if (side_q[D_STAGES-1].go) begin
      out_year  <= YW'(yr_c);
      out_month <= mo_c;
      out_day   <= gda_pkg::DAY_W'(d7_doy - gda_pkg::month_start(d7_mp) + 9'd1);
    end else begin
      out_year  <= '0;
      out_month <= '0;
      out_day   <= '0;
    end
    day_difference <= side_q[D_STAGES-1].diff;
    a_less_than_b  <= side_q[D_STAGES-1].lt;
    a_equals_b     <= side_q[D_STAGES-1].eq;
    input_valid    <= side_q[D_STAGES-1].va;
    range_error    <= side_q[D_STAGES-1].rerr;
  end

  // ---------------------------------------------------------------- valid line
  // Advance the valid bits with the data; reset drops every item in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
      f3_vld <= 1'b0;
      f4_vld <= 1'b0;
      dvld   <= '0;
      done   <= 1'b0;
    end else begin
      f1_vld <= start && !busy;
      f2_vld <= f1_vld;
      f3_vld <= f2_vld;
      f4_vld <= f3_vld;
      dvld   <= {dvld[D_STAGES-2:0], f4_vld};
      done   <= dvld[D_STAGES-1];
    end
  end

  // ---------------------------------------------------------------- assertions
  a_latency: assert property (@(posedge clk) disable iff (rst) start |-> ##LATENCY done)
    else $error("accepted transfer did not complete after the pipeline latency");
  a_rerr_needs_valid: assert property (@(posedge clk) done && range_error |-> input_valid)
    else $error("range error raised for an illegal date");
  a_rerr_zero: assert property (@(posedge clk)
    done && range_error |-> out_year == '0 && out_month == '0 && out_day == '0)
    else $error("date fields not cleared on range error");
  a_date_xor_diff: assert property (@(posedge clk)
    done && out_month != '0 |-> day_difference == '0 && out_day != '0 && !range_error)
    else $error("date result mixed with difference or error");

endmodule

>>> tb/gda_checker.sv
// Date-result checker: predicts each transfer from the accepted inputs and compares.
`timescale 1ns / 1ps

module gda_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic [1:0]                             mode,
  input  logic [gda_pkg::YEAR_W-1:0]             year_a,
  input  logic [gda_pkg::MONTH_W-1:0]            month_a,
  input  logic [gda_pkg::DAY_W-1:0]              day_a,
  input  logic [gda_pkg::YEAR_W-1:0]             year_b,
  input  logic [gda_pkg::MONTH_W-1:0]            month_b,
  input  logic [gda_pkg::DAY_W-1:0]              day_b,
  input  logic signed [gda_pkg::OFFSET_BITS-1:0] offset_days,
  input  logic                                   done,
  input  logic [gda_pkg::YEAR_W-1:0]             out_year,
  input  logic [gda_pkg::MONTH_W-1:0]            out_month,
  input  logic [gda_pkg::DAY_W-1:0]              out_day,
  input  logic [gda_pkg::DIFF_W-1:0]             day_difference,
  input  logic                                   a_less_than_b,
  input  logic                                   a_equals_b,
  input  logic                                   input_valid,
  input  logic                                   range_error,
  output int                                     fail_count,
  output int                                     pending
);

  typedef struct {
    logic [gda_pkg::YEAR_W-1:0]  yr;
    logic [gda_pkg::MONTH_W-1:0] mo;
    logic [gda_pkg::DAY_W-1:0]   dy;
    logic [gda_pkg::DIFF_W-1:0]  diff;
    logic                        lt, eq, va, rerr;
  } date_result_t;

  date_result_t expected_dates[$];

  assign pending = expected_dates.size();

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic bit legal_date(longint y, longint m, longint d);
    longint len;
    if (m < 1 || m > 12) return 0;
    case (m)
      4, 6, 9, 11: len = 30;
      2:           len = leap_year(y) ? 29 : 28;
      default:     len = 31;
    endcase
    return d >= 1 && d <= len;
  endfunction

  // day count from 1 March of year -400
  function automatic longint day_number(longint y, longint m, longint d);
    longint yy, mm;
    yy = y + 400 - (m <= 2 ? 1 : 0);
    mm = (m <= 2) ? m + 9 : m - 3;
    return yy * 365 + yy / 4 - yy / 100 + yy / 400 + (153 * mm + 2) / 5 + d - 1;
  endfunction

  function automatic date_result_t predict_date(logic [1:0] md, longint ya, longint ma,
                                                longint da, longint yb, longint mb,
                                                longint db, longint off);
    date_result_t r;
    longint s, z, era, doe, yoe, doy, mp, mo, t;
    r = '{default: '0};
    r.va = legal_date(ya, ma, da);
    r.lt = (ya < yb) || (ya == yb && ma < mb) || (ya == yb && ma == mb && da < db);
    r.eq = (ya == yb) && (ma == mb) && (da == db);
    if (r.va && (md == gda_pkg::MODE_ADD || md == gda_pkg::MODE_SUB)) begin
      s = day_number(ya, ma, da) + ((md == gda_pkg::MODE_ADD) ? off : -off);
      if (s < day_number(1, 1, 1) || s > day_number(gda_pkg::MAX_YEAR, 12, 31)) begin
        r.rerr = 1'b1;
      end else begin
        z   = s;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        mo  = (mp < 10) ? mp + 3 : mp - 9;
        r.dy = gda_pkg::DAY_W'(doy - (153 * mp + 2) / 5 + 1);
        r.mo = gda_pkg::MONTH_W'(mo);
        r.yr = gda_pkg::YEAR_W'(yoe + era * 400 + (mo <= 2 ? 1 : 0) - 400);
      end
    end else if (r.va && md == gda_pkg::MODE_DIFF && legal_date(yb, mb, db)) begin
      t = day_number(ya, ma, da) - day_number(yb, mb, db);
      if (t < 0) t = -t;
      if (t > gda_pkg::DIFF_MAX) t = gda_pkg::DIFF_MAX;
      r.diff = gda_pkg::DIFF_W'(t);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    date_result_t want;
    if (!rst && done) begin
      if (expected_dates.size() == 0) begin
        report_mismatch("result with no transfer outstanding", 1, 0);
      end else begin
        want = expected_dates.pop_front();
        if (out_year != want.yr) report_mismatch("out_year", out_year, want.yr);
        if (out_month != want.mo) report_mismatch("out_month", out_month, want.mo);
        if (out_day != want.dy) report_mismatch("out_day", out_day, want.dy);
        if (day_difference != want.diff)
          report_mismatch("day_difference", day_difference, want.diff);
        if (a_less_than_b != want.lt) report_mismatch("a_less_than_b", a_less_than_b, want.lt);
        if (a_equals_b != want.eq) report_mismatch("a_equals_b", a_equals_b, want.eq);
        if (input_valid != want.va) report_mismatch("input_valid", input_valid, want.va);
        if (range_error != want.rerr) report_mismatch("range_error", range_error, want.rerr);
      end
    end
    // queue after the pop so a same-edge transfer never meets its own result
    if (!rst && start && !busy)
      expected_dates.push_back(predict_date(mode, year_a, month_a, day_a, year_b, month_b,
                                            day_b, longint'(offset_days)));
  end

endmodule

>>> tb/testbench.sv
// Testbench top: stimulus, idling phases and verdict for the date arithmetic core.
`timescale 1ns / 1ps

module testbench;

  logic                                   clk = 1'b0;
  logic                                   rst = 1'b1;
  logic                                   start = 1'b0;
  logic                                   busy;
  logic [1:0]                             mode = gda_pkg::MODE_ADD;
  logic [gda_pkg::YEAR_W-1:0]             year_a = '0, year_b = '0;
  logic [gda_pkg::MONTH_W-1:0]            month_a = '0, month_b = '0;
  logic [gda_pkg::DAY_W-1:0]              day_a = '0, day_b = '0;
  logic signed [gda_pkg::OFFSET_BITS-1:0] offset_days = '0;
  logic                                   done, a_less_than_b, a_equals_b, input_valid;
  logic                                   range_error;
  logic [gda_pkg::YEAR_W-1:0]             out_year;
  logic [gda_pkg::MONTH_W-1:0]            out_month;
  logic [gda_pkg::DAY_W-1:0]              out_day;
  logic [gda_pkg::DIFF_W-1:0]             day_difference;
  int                                     fail_count, pending;
  int                                     idle_pct;

  // 4 ns period
  always #2 clk = ~clk;

  gregorian_date_arithmetic_core DUT (.*);
  gda_checker checker_inst (.*);

  // Drive one transfer: raise start and hold it until an edge with busy low takes it; the
  // task leaves start high and the caller drops it when it does not follow straight on. Idle
  // gaps are inserted before the transfer according to the phase's idle percentage.
  task automatic send_date(logic [1:0] md, int ya, int ma, int da, int yb, int mb, int db,
                           longint off);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    mode        <= md;
    year_a      <= gda_pkg::YEAR_W'(ya);
    month_a     <= gda_pkg::MONTH_W'(ma);
    day_a       <= gda_pkg::DAY_W'(da);
    year_b      <= gda_pkg::YEAR_W'(yb);
    month_b     <= gda_pkg::MONTH_W'(mb);
    day_b       <= gda_pkg::DAY_W'(db);
    offset_days <= gda_pkg::OFFSET_BITS'(off);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Mostly legal dates, with the occasional out-of-table field to exercise validity.
  task automatic send_random;
    int  ya, ma, da, yb, mb, db, sel;
    longint off;
    sel = $urandom_range(9, 0);
    ya  = (sel == 0) ? $urandom_range(16383, 0) : $urandom_range(gda_pkg::MAX_YEAR, 0);
    ma  = (sel == 1) ? $urandom_range(15, 0) : $urandom_range(12, 1);
    da  = (sel == 2) ? $urandom_range(31, 0) : $urandom_range(28, 1);
    // B close to A half of the time so equality and small differences happen
    if ($urandom_range(1, 0)) begin
      yb = ya; mb = ma; db = $urandom_range(1, 0) ? da : $urandom_range(31, 0);
    end else begin
      yb = (sel == 3) ? $urandom_range(16383, 0) : $urandom_range(gda_pkg::MAX_YEAR, 0);
      mb = (sel == 4) ? $urandom_range(15, 0) : $urandom_range(12, 1);
      db = $urandom_range(31, 0);
    end
    case ($urandom_range(3, 0))
      0:       off = $signed(23'($urandom()));
      1:       off = longint'($urandom_range(800, 0)) - 400;
      default: off = longint'($urandom_range(2000000, 0)) - 1000000;
    endcase
    send_date(2'($urandom_range(3, 0)), ya, ma, da, yb, mb, db, off);
  endtask

  initial begin
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, leap rule, each mode, range edges, illegal A and B
    send_date(gda_pkg::MODE_ADD, 1, 1, 1, 1, 1, 1, 0);
    send_date(gda_pkg::MODE_SUB, 1, 1, 1, 0, 0, 0, 1);
    send_date(gda_pkg::MODE_ADD, gda_pkg::MAX_YEAR, 12, 31, gda_pkg::MAX_YEAR, 12, 31, 1);
    send_date(gda_pkg::MODE_ADD, 2000, 2, 29, 1900, 2, 29, 365);
    send_date(gda_pkg::MODE_SUB, 1900, 3, 1, 2000, 2, 28, 1);
    send_date(gda_pkg::MODE_ADD, 2024, 2, 28, 2024, 2, 29, 1);
    send_date(gda_pkg::MODE_ADD, 5000, 6, 15, 0, 0, 0, 4194303);
    send_date(gda_pkg::MODE_ADD, 5000, 6, 15, 16383, 15, 31, -4194304);
    send_date(gda_pkg::MODE_SUB, 5000, 6, 15, 1, 1, 1, -4194304);
    send_date(gda_pkg::MODE_DIFF, 1, 1, 1, 16383, 12, 31, 0);
    send_date(gda_pkg::MODE_DIFF, 16383, 12, 31, 0, 1, 1, 0);
    send_date(gda_pkg::MODE_DIFF, 2000, 1, 1, 2000, 2, 30, 0);
    send_date(gda_pkg::MODE_DIFF, 0, 2, 29, 0, 3, 1, 0);
    send_date(gda_pkg::MODE_CMP, 1999, 13, 1, 1999, 12, 31, 0);
    send_date(gda_pkg::MODE_ADD, 2001, 4, 31, 2001, 4, 30, 5);
    send_date(gda_pkg::MODE_ADD, 2001, 0, 0, 2001, 0, 0, 5);
    send_date(gda_pkg::MODE_CMP, 16383, 15, 31, 16383, 15, 31, -1);
    send_date(gda_pkg::MODE_ADD, 0, 12, 31, 1, 1, 1, 1);
    send_date(gda_pkg::MODE_SUB, gda_pkg::MAX_YEAR, 12, 31, 0, 0, 0, -1);
    start <= 1'b0;

    // hold off until the pipeline has drained once
    while (pending != 0) @(posedge clk);

    // random phases: no idling, heavy idling, light idling, then back to back
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 63 : (p == 2) ? 10 : 0;
      repeat (200) send_random();
    end
    start <= 1'b0;

    fork
      while (pending != 0) @(posedge clk);
    join
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** gregorian_date_arithmetic_core: PASSED **");
    end else begin
      $display("** gregorian_date_arithmetic_core: FAILED **");
    end
    $finish;
  end

  // watchdog well beyond the slowest correct run
  initial begin
    #2000000;
    $display("** gregorian_date_arithmetic_core: FAILED **");
    $finish;
  end

endmodule
